@@ hw/rtl/limit_order_book_matcher_macros.svh @@
`ifndef LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH

// Invariant checked on every clock edge outside reset
`define LOBM_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Implication checked on every clock edge outside reset
`define LOBM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/lobm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lobm_pkg;

	// 1e9 + 7
	localparam logic [29:0] BACKLOG_MODULUS = 30'd1000000007;

	// book identifiers
	localparam logic BOOK_BUY  = 1'b0;
	localparam logic BOOK_SELL = 1'b1;

	// incoming order beat
	typedef struct packed {
		logic [30:0] price;
		logic [30:0] amount;
		logic        side;
	} order_t;

	// result beat
	typedef struct packed {
		logic [29:0] backlog_mod;
		logic        book_full;
	} result_t;

	// book entry: price first so a plain compare orders by price, then amount
	typedef struct packed {
		logic [30:0] price;
		logic [30:0] amount;
	} entry_t;

	// classified order handed from the front to the engine
	typedef struct packed {
		order_t ord;
		logic   zero_amt;
	} cls_order_t;

endpackage

`default_nettype wire

@@ hw/rtl/limit_order_book_matcher.sv @@
// Channel   Beat type  Handshake          Accepted when
// order     order_t    push / full        push && !full
// result    result_t   pop / empty        pop && !empty
//
// One order at a time: matched against the far book with a sift down after
// each consumed or partly filled top, remainder inserted with a sift up, then
// backlog reduced modulo 1e9+7 and handed over. The single-port book memory
// sets the cost of each heap level. Reset clears counts and backlog at once;
// book memory is not cleared. Two-deep queues on both sides absorb stalls.
`timescale 1ns / 1ps
`default_nettype none

module limit_order_book_matcher
	import lobm_pkg::*;
#(
	parameter int BOOK_DEPTH = 1024
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	output logic         full,
	input  wire order_t  order,
	output logic         empty,
	input  wire logic    pop,
	output result_t      result
);

	logic       ord_valid;
	cls_order_t ord;
	logic       ord_pop;
	logic       res_full;
	logic       res_push;
	result_t    res;

	// order intake and classification
	lobm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.order     (order),
		.ord_valid (ord_valid),
		.ord       (ord),
		.ord_pop   (ord_pop)
	);

	// matching and book upkeep
	lobm_engine #(
		.BOOK_DEPTH (BOOK_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.ord_valid (ord_valid),
		.ord       (ord),
		.ord_pop   (ord_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	// result queue
	lobm_result_q u_result_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_full (res_full),
		.res      (res),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire

@@ hw/rtl/lobm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lobm_front
	import lobm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire order_t     order,
	output logic            ord_valid,
	output cls_order_t      ord,
	input  wire logic       ord_pop
);

	cls_order_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (fill_q == 2'd2);
	assign ord_valid = (fill_q != 2'd0);
	assign ord       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = ord_pop && ord_valid;

	// payload slots, tagged with the zero-amount class on entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q].ord      <= order;
			slot_q[wr_ptr_q].zero_amt <= (order.amount == 31'd0);
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lobm_result_q.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lobm_result_q
	import lobm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_push,
	output logic         res_full,
	input  wire result_t res,
	output logic         empty,
	input  wire logic    pop,
	output result_t      result
);

	result_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign res_full = (fill_q == 2'd2);
	assign empty    = (fill_q == 2'd0);
	assign result   = slot_q[rd_ptr_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	// payload slots
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= res;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lobm_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "limit_order_book_matcher_macros.svh"

module lobm_engine
	import lobm_pkg::*;
#(
	parameter int BOOK_DEPTH = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       ord_valid,
	input  wire cls_order_t ord,
	output logic            ord_pop,
	input  wire logic       res_full,
	output logic            res_push,
	output result_t         res
);

	localparam int IW    = $clog2(BOOK_DEPTH);
	localparam int CW    = $clog2(BOOK_DEPTH + 1);
	localparam int TW    = CW + 32;
	localparam int KMAX  = TW - 30;
	localparam int KW    = $clog2(KMAX + 1);
	localparam int MEM_N = 2 * (1 << IW);

	typedef enum logic [3:0] {
		S_IDLE, S_MCHK, S_MTOP, S_MLAST, S_DL, S_DR, S_DDEC,
		S_INS, S_UP, S_UDEC, S_MINIT, S_MOD, S_PUSH
	} state_t;

	function automatic logic ranks_above(entry_t a, entry_t b, logic is_max);
		return is_max ? (a > b) : (a < b);
	endfunction

	// both books share one memory, book id as the top address bit
	logic [61:0] mem [MEM_N];
	logic [61:0] rdata_q;

	state_t        state_q;
	logic [30:0]   price_q;
	logic [30:0]   amt_q;
	logic          side_q;
	logic          full_q;
	logic          bk_q;
	logic [IW-1:0] idx_q;
	entry_t        cur_q;
	entry_t        lch_q;
	logic          rvld_q;
	logic [CW-1:0] buy_cnt_q;
	logic [CW-1:0] sell_cnt_q;
	logic [TW-1:0] total_q;
	logic [TW-1:0] mod_r_q;
	logic [KW-1:0] k_q;

	logic          rd_en;
	logic [IW:0]   rd_addr;
	logic          wr_en;
	logic [IW:0]   wr_addr;
	logic [61:0]   wr_data;

	logic          opp_bk;
	logic [CW-1:0] opp_cnt;
	logic [CW-1:0] own_cnt;
	logic [CW-1:0] cur_cnt;
	logic [IW:0]   n_ext;
	entry_t        top;
	logic          crosses;
	logic          is_max;
	logic [IW:0]   l_ix;
	logic [IW:0]   r_ix;
	logic [IW-1:0] p_ix;
	logic [IW-1:0] last_ix;
	entry_t        rch;
	logic          b_is_l;
	entry_t        bestv;
	logic          b_is_r;
	logic          up_swap;
	logic [TW-1:0] mod_sub;

	// decode of the current heap step
	always_comb begin
		opp_bk  = ~side_q;
		opp_cnt = side_q ? buy_cnt_q : sell_cnt_q;
		own_cnt = side_q ? sell_cnt_q : buy_cnt_q;
		cur_cnt = bk_q ? sell_cnt_q : buy_cnt_q;
		n_ext   = (IW + 1)'(cur_cnt);
		top     = entry_t'(rdata_q);
		crosses = side_q ? (top.price >= price_q) : (top.price <= price_q);
		is_max  = (bk_q == BOOK_BUY);
		l_ix    = {idx_q, 1'b1};
		r_ix    = l_ix + 1'b1;
		p_ix    = (idx_q - 1'b1) >> 1;
		last_ix = cur_cnt[IW-1:0] - 1'b1;
		rch     = entry_t'(rdata_q);
		b_is_l  = ranks_above(lch_q, cur_q, is_max);
		bestv   = b_is_l ? lch_q : cur_q;
		b_is_r  = rvld_q && ranks_above(rch, bestv, is_max);
		up_swap = ranks_above(cur_q, entry_t'(rdata_q), is_max);
		mod_sub = TW'(BACKLOG_MODULUS) << k_q;
	end

	// book memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_MCHK: begin
				if (amt_q != 31'd0 && opp_cnt != '0) begin
					rd_en   = 1'b1;
					rd_addr = {opp_bk, IW'(0)};
				end
			end
			S_MTOP: begin
				if (crosses && top.amount <= amt_q) begin
					rd_en   = 1'b1;
					rd_addr = {bk_q, last_ix};
				end
			end
			S_DL: begin
				if (l_ix < n_ext) begin
					rd_en   = 1'b1;
					rd_addr = {bk_q, l_ix[IW-1:0]};
				end else begin
					wr_en   = 1'b1;
					wr_addr = {bk_q, idx_q};
					wr_data = cur_q;
				end
			end
			S_DR: begin
				if (r_ix < n_ext) begin
					rd_en   = 1'b1;
					rd_addr = {bk_q, r_ix[IW-1:0]};
				end
			end
			S_DDEC: begin
				wr_en   = 1'b1;
				wr_addr = {bk_q, idx_q};
				wr_data = b_is_r ? rch : bestv;
			end
			S_UP: begin
				if (idx_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = {bk_q, idx_q};
					wr_data = cur_q;
				end else begin
					rd_en   = 1'b1;
					rd_addr = {bk_q, p_ix};
				end
			end
			S_UDEC: begin
				wr_en   = 1'b1;
				wr_addr = {bk_q, idx_q};
				wr_data = up_swap ? rdata_q : cur_q;
			end
			default: ;
		endcase
	end

	// book memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	assign ord_pop  = (state_q == S_IDLE) && ord_valid;
	assign res_push = (state_q == S_PUSH) && !res_full;
	assign res      = '{backlog_mod: mod_r_q[29:0], book_full: full_q};

	// matching sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			buy_cnt_q  <= '0;
			sell_cnt_q <= '0;
			total_q    <= '0;
			price_q    <= '0;
			amt_q      <= '0;
			side_q     <= 1'b0;
			full_q     <= 1'b0;
			bk_q       <= BOOK_BUY;
			idx_q      <= '0;
			cur_q      <= '0;
			lch_q      <= '0;
			rvld_q     <= 1'b0;
			mod_r_q    <= '0;
			k_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ord_valid) begin
						price_q <= ord.ord.price;
						amt_q   <= ord.ord.amount;
						side_q  <= ord.ord.side;
						full_q  <= 1'b0;
						state_q <= ord.zero_amt ? S_MINIT : S_MCHK;
					end
				end
				S_MCHK: begin
					if (amt_q != 31'd0 && opp_cnt != '0) begin
						bk_q    <= opp_bk;
						state_q <= S_MTOP;
					end else begin
						state_q <= S_INS;
					end
				end
				S_MTOP: begin
					if (!crosses) begin
						state_q <= S_INS;
					end else if (top.amount <= amt_q) begin
						amt_q   <= amt_q - top.amount;
						total_q <= total_q - TW'(top.amount);
						if (bk_q == BOOK_SELL) sell_cnt_q <= sell_cnt_q - 1'b1;
						else                   buy_cnt_q  <= buy_cnt_q - 1'b1;
						state_q <= S_MLAST;
					end else begin
						total_q <= total_q - TW'(amt_q);
						amt_q   <= '0;
						cur_q   <= '{price: top.price, amount: top.amount - amt_q};
						idx_q   <= '0;
						state_q <= S_DL;
					end
				end
				S_MLAST: begin
					// last entry moves to the top and sifts down
					cur_q   <= entry_t'(rdata_q);
					idx_q   <= '0;
					state_q <= (cur_cnt == '0) ? S_MCHK : S_DL;
				end
				S_DL: begin
					state_q <= (l_ix < n_ext) ? S_DR : S_MCHK;
				end
				S_DR: begin
					lch_q   <= entry_t'(rdata_q);
					rvld_q  <= (r_ix < n_ext);
					state_q <= S_DDEC;
				end
				S_DDEC: begin
					priority if (b_is_r) begin
						idx_q   <= r_ix[IW-1:0];
						state_q <= S_DL;
					end else if (b_is_l) begin
						idx_q   <= l_ix[IW-1:0];
						state_q <= S_DL;
					end else begin
						state_q <= S_MCHK;
					end
				end
				S_INS: begin
					priority if (amt_q == 31'd0) begin
						state_q <= S_MINIT;
					end else if (own_cnt == CW'(BOOK_DEPTH)) begin
						full_q  <= 1'b1;
						state_q <= S_MINIT;
					end else begin
						bk_q    <= side_q;
						idx_q   <= own_cnt[IW-1:0];
						cur_q   <= '{price: price_q, amount: amt_q};
						total_q <= total_q + TW'(amt_q);
						if (side_q == BOOK_SELL) sell_cnt_q <= sell_cnt_q + 1'b1;
						else                     buy_cnt_q  <= buy_cnt_q + 1'b1;
						state_q <= S_UP;
					end
				end
				S_UP: begin
					state_q <= (idx_q == '0) ? S_MINIT : S_UDEC;
				end
				S_UDEC: begin
					if (up_swap) begin
						idx_q   <= p_ix;
						state_q <= S_UP;
					end else begin
						state_q <= S_MINIT;
					end
				end
				S_MINIT: begin
					mod_r_q <= total_q;
					k_q     <= KW'(KMAX);
					state_q <= S_MOD;
				end
				S_MOD: begin
					// restoring reduction, one shifted modulus per cycle
					if (mod_r_q >= mod_sub) mod_r_q <= mod_r_q - mod_sub;
					if (k_q == '0) state_q <= S_PUSH;
					else           k_q <= k_q - 1'b1;
				end
				S_PUSH: begin
					if (!res_full) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`LOBM_ASSERT(a_buy_cnt_bound, buy_cnt_q <= CW'(BOOK_DEPTH), "buy count above depth")
	`LOBM_ASSERT(a_sell_cnt_bound, sell_cnt_q <= CW'(BOOK_DEPTH), "sell count above depth")
	`LOBM_ASSERT_IMP(a_res_reduced, res_push, mod_r_q < TW'(BACKLOG_MODULUS),
		"backlog not reduced")
	`LOBM_ASSERT_IMP(a_full_has_rest, res_push && full_q, amt_q != 31'd0,
		"book full flagged with no remainder")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import lobm_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int IDLE_LIMIT = 200000;
	localparam int TAIL_WAIT  = 300;
	localparam logic [30:0] MAX31 = 31'h7fff_ffff;

	// matching engine mirror plus queue of results still owed by the block
	class book_scoreboard;
		logic [61:0] heap [2][DEPTH];
		int          depth_used [2];
		logic [63:0] resting;
		result_t     owed [$];
		int          n_orders, n_checked, n_drops, n_errors;

		function new();
			depth_used[0] = 0;
			depth_used[1] = 0;
			resting = '0;
		endfunction

		// buy book is a max heap, sell book a min heap
		function bit outranks(logic [61:0] a, logic [61:0] b, logic bk);
			return (bk == BOOK_BUY) ? (a > b) : (a < b);
		endfunction

		function void sift_up(logic bk, int i);
			int p;
			logic [61:0] t;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (!outranks(heap[bk][i], heap[bk][p], bk))
					break;
				t = heap[bk][i]; heap[bk][i] = heap[bk][p]; heap[bk][p] = t;
				i = p;
			end
		endfunction

		function void sift_down(logic bk, int i);
			int l, best, n;
			logic [61:0] t;
			n = depth_used[bk];
			forever begin
				l = 2 * i + 1;
				best = i;
				if (l < n && outranks(heap[bk][l], heap[bk][best], bk))
					best = l;
				if (l + 1 < n && outranks(heap[bk][l + 1], heap[bk][best], bk))
					best = l + 1;
				if (best == i)
					break;
				t = heap[bk][i]; heap[bk][i] = heap[bk][best]; heap[bk][best] = t;
				i = best;
			end
		endfunction

		// accepted order: match against the far book, rest the remainder
		function void note_order(order_t o);
			logic        own, opp;
			logic [30:0] left, tp, ta;
			result_t     r;
			own  = o.side;
			opp  = ~o.side;
			left = o.amount;
			r.book_full = 1'b0;
			while (left != 0 && depth_used[opp] > 0) begin
				tp = heap[opp][0][61:31];
				ta = heap[opp][0][30:0];
				if (own == BOOK_SELL ? (tp < o.price) : (tp > o.price))
					break;
				if (ta <= left) begin
					left    -= ta;
					resting -= 64'(ta);
					depth_used[opp]--;
					heap[opp][0] = heap[opp][depth_used[opp]];
				end else begin
					resting -= 64'(left);
					heap[opp][0] = {tp, ta - left};
					left = '0;
				end
				sift_down(opp, 0);
			end
			if (left != 0) begin
				if (depth_used[own] < DEPTH) begin
					heap[own][depth_used[own]] = {o.price, left};
					depth_used[own]++;
					sift_up(own, depth_used[own] - 1);
					resting += 64'(left);
				end else begin
					r.book_full = 1'b1;
					n_drops++;
				end
			end
			r.backlog_mod = 30'(resting % 64'd1000000007);
			owed.push_back(r);
			n_orders++;
		endfunction

		function void check_result(result_t got);
			result_t want;
			n_checked++;
			if (owed.size() == 0) begin
				$display("%0t: result with nothing owed: backlog %0d full %0b",
					$time, got.backlog_mod, got.book_full);
				n_errors++;
				return;
			end
			want = owed.pop_front();
			if (got.backlog_mod !== want.backlog_mod) begin
				$display("%0t: backlog_mod expected %0d actual %0d",
					$time, want.backlog_mod, got.backlog_mod);
				n_errors++;
			end
			if (got.book_full !== want.book_full) begin
				$display("%0t: book_full expected %0b actual %0b",
					$time, want.book_full, got.book_full);
				n_errors++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    pop = 1'b0;
	logic    full, empty;
	order_t  order = '0;
	result_t result;

	book_scoreboard sb = new();
	bit  sink_hold_req = 0;
	bit  no_gaps = 0;
	int  idle_cycles = 0;

	limit_order_book_matcher #(.BOOK_DEPTH(DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.order  (order),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #5 clk = ~clk;

	function int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 6);
	endfunction

	// drive one order beat and wait for it to be taken
	task automatic send_order(logic [30:0] p, logic [30:0] a, logic s);
		int gap;
		order_t o;
		gap = draw_gap();
		o.price = p; o.amount = a; o.side = s;
		if (gap > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk) begin
			push  <= 1'b1;
			order <= o;
		end
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_order(o);
	endtask

	task automatic wait_all_results();
		@(negedge clk) push <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
	endtask

	task automatic random_order();
		logic [30:0] p, a;
		case ($urandom_range(0, 9))
			0: p = 31'($urandom);
			1: p = ($urandom_range(0, 1) != 0) ? MAX31 : '0;
			default: p = 31'(100 + $urandom_range(0, 15));
		endcase
		case ($urandom_range(0, 9))
			0: a = 31'($urandom);
			1: a = '0;
			2: a = MAX31 - 31'($urandom_range(0, 3));
			default: a = 31'($urandom_range(1, 1000));
		endcase
		send_order(p, a, 1'($urandom));
	endtask

	// result side: random pops, one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 0;
				@(negedge clk) pop <= 1'b0;
				repeat (500) @(negedge clk);
			end
			gap = draw_gap();
			if (gap > 0) begin
				@(negedge clk) pop <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			sb.check_result(result);
		end
	end

	// watchdog on cycles with no beat moving either way
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: zero amount, extremes, equal prices, partial and exhausted fills
		send_order(31'd50, '0, BOOK_BUY);
		send_order(MAX31, '0, BOOK_SELL);
		send_order(31'd200, 31'd10, BOOK_SELL);
		send_order(31'd200, 31'd30, BOOK_SELL);
		send_order(31'd200, 31'd20, BOOK_SELL);
		send_order(31'd199, 31'd5, BOOK_BUY);
		send_order(31'd200, 31'd15, BOOK_BUY);
		send_order(31'd300, 31'd20, BOOK_BUY);
		send_order(31'd150, 31'd7, BOOK_BUY);
		send_order(31'd150, 31'd9, BOOK_BUY);
		send_order(31'd150, 31'd8, BOOK_BUY);
		send_order(31'd150, 31'd12, BOOK_SELL);
		send_order(31'd151, 31'd100, BOOK_SELL);
		send_order('0, MAX31, BOOK_BUY);
		send_order(MAX31, MAX31, BOOK_BUY);
		send_order(MAX31, MAX31, BOOK_SELL);
		send_order('0, MAX31, BOOK_SELL);
		send_order('0, 31'd1, BOOK_SELL);
		send_order(MAX31, MAX31, BOOK_BUY);
		send_order(MAX31, 31'd1, BOOK_BUY);
		wait_all_results();

		// random mix around a narrow price band, bursts without gaps
		for (int i = 0; i < 120; i++) begin
			no_gaps = ((i / 40) % 4) == 1;
			random_order();
		end
		wait_all_results();

		// clear the sell book, then fill the buy book to the brim
		no_gaps = 0;
		send_order(MAX31, MAX31, BOOK_BUY);
		send_order('0, MAX31, BOOK_SELL);
		wait_all_results();
		sink_hold_req = 1;
		while (sb.depth_used[BOOK_BUY] < DEPTH)
			send_order(31'($urandom_range(0, 3)), 31'($urandom_range(1, 1 << 20)), BOOK_BUY);
		for (int i = 0; i < 12; i++)
			send_order(31'($urandom_range(0, 3)), 31'($urandom_range(0, 9)), BOOK_BUY);
		send_order(MAX31, 31'd3, BOOK_SELL);
		send_order(31'd2, 31'd5, BOOK_SELL);
		send_order('0, MAX31, BOOK_BUY);
		wait_all_results();

		// sweep the full book and finish with fresh random traffic
		send_order('0, MAX31, BOOK_SELL);
		send_order('0, MAX31, BOOK_SELL);
		for (int i = 0; i < 60; i++) begin
			no_gaps = ((i / 20) % 3) == 2;
			random_order();
		end
		wait_all_results();

		repeat (TAIL_WAIT) @(posedge clk);
		$display("Orders sent: %0d, results checked: %0d, full-book drops: %0d",
			sb.n_orders, sb.n_checked, sb.n_drops);
		if (sb.n_errors == 0 && sb.owed.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
